// ===== sv/rcsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsfr_pkg: shared constants and types for the serial frame receiver
// Frame geometry, store addressing and the write-port bundle that the
// receive logic hands to the frame buffer.
// ----------------------------------------------------------------------------
package rcsfr_pkg;

  localparam int CHANNELS    = 14;
  localparam int FRAME_BYTES = 2 * CHANNELS + 4;
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Byte positions of note inside a frame
  localparam logic [ADDR_W-1:0] CHK_LO_POS = ADDR_W'(FRAME_BYTES - 2);
  localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(FRAME_BYTES - 1);

  localparam logic [15:0] CHECK_INIT   = 16'hFFFF;
  localparam logic [7:0]  HEADER_RESET = 8'd32;

  // Register index of header_value on the APB port (paddr[2])
  localparam logic REG_HEADER = 1'b0;

  // Receiver states
  typedef enum logic [1:0] {
    RX_IDLE  = 2'b01,
    RX_FRAME = 2'b10
  } rx_state_t;

  // Write port into the frame store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } fb_wr_t;

endpackage

// ===== sv/rcsfr_frame_buf.sv =====
// ----------------------------------------------------------------------------
// rcsfr_frame_buf: frame store and readout sequencer
// Holds the bytes of the frame being received in a synchronous memory and,
// on start, reads the whole frame out one item per cycle while out_stall is
// low, through an output register with a valid/stall handshake.
// ----------------------------------------------------------------------------
module rcsfr_frame_buf import rcsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  fb_wr_t            wr,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        frame_byte,
  output logic [ADDR_W-1:0] byte_position,
  output logic              last_byte
);

  logic [7:0]        mem [STORE_DEPTH];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] rd_pos;
  logic              emitting;
  logic              rd_pend;
  logic              load;
  logic              issue;

  // Move read data to the output register when it is empty or draining
  assign load  = rd_pend && (!out_valid || !out_stall);
  // Issue a read when the read data slot is free or frees this cycle
  assign issue = emitting && (!rd_pend || load);
  assign busy  = emitting || rd_pend;

  // Store port: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Readout sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      rd_pend  <= 1'b0;
      rd_ptr   <= '0;
    end else begin
      if (start) begin
        emitting <= 1'b1;
        rd_ptr   <= '0;
      end else if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
        if (rd_ptr == LAST_POS) begin
          emitting <= 1'b0;
        end
      end
      rd_pend <= issue || (rd_pend && !load);
    end
  end

  // Remember the position of the read in flight
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_pos <= rd_ptr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte    <= rd_data;
      byte_position <= rd_pos;
      last_byte     <= (rd_pos == LAST_POS);
    end
  end

endmodule

// ===== sv/rc_serial_frame_receiver.sv =====
// A good frame's first item leaves via the sequencer, store read and output registers.
// Throughput: one received byte per cycle while in_stall is low; a good frame reads out
// one item per cycle without output stall, paced by the single read port of the store.
// Input is stalled while a frame is read out.
// Reset (rst, synchronous): idle, check value all ones, header_value 32, no output pending.
// The frame store is not cleared; every position is written before it is read.
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver: RC receiver serial frame parser
// Hunts for the header byte, collects a fixed-length frame, checks the
// trailing little-endian check word and emits good frames byte by byte.
// ----------------------------------------------------------------------------
module rc_serial_frame_receiver import rcsfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        frame_byte,
  output logic [ADDR_W-1:0] byte_position,
  output logic              last_byte
);

  logic [7:0]        header_value;
  rx_state_t         state;
  rx_state_t         state_next;
  logic [ADDR_W-1:0] byte_count;
  logic [ADDR_W-1:0] byte_count_next;
  logic [15:0]       running_sum;
  logic [15:0]       running_sum_next;
  logic [7:0]        chk_lo;
  logic              accept;
  logic              start;
  logic              busy;
  fb_wr_t            wr;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEADER) ? {24'd0, header_value} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEADER) begin
      header_value <= pwdata[7:0];
    end
  end

  // Hold input off while a frame is read out
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // Receive path: store, accumulate check value, detect end of frame
  always_comb begin
    state_next       = state;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    start            = 1'b0;
    wr.en            = 1'b0;
    wr.addr          = byte_count;
    wr.data          = rx_byte;
    if (accept) begin
      unique case (state)
        RX_IDLE: begin
          if (rx_byte == header_value) begin
            wr.en            = 1'b1;
            wr.addr          = '0;
            byte_count_next  = ADDR_W'(1);
            running_sum_next = CHECK_INIT - {8'd0, rx_byte};
            state_next       = RX_FRAME;
          end
        end
        RX_FRAME: begin
          wr.en           = 1'b1;
          byte_count_next = byte_count + 1'b1;
          if (byte_count < CHK_LO_POS) begin
            running_sum_next = running_sum - {8'd0, rx_byte};
          end
          if (byte_count == LAST_POS) begin
            state_next = RX_IDLE;
            start      = ({rx_byte, chk_lo} == running_sum);
          end
        end
        default: begin
          state_next = RX_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= RX_IDLE;
      byte_count  <= '0;
      running_sum <= CHECK_INIT;
    end else begin
      state       <= state_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Capture the low byte of the check word as it arrives
  always_ff @(posedge clk) begin
    if (accept && state == RX_FRAME && byte_count == CHK_LO_POS) begin
      chk_lo <= rx_byte;
    end
  end

  rcsfr_frame_buf u_frame_buf (
    .clk           (clk),
    .rst           (rst),
    .wr            (wr),
    .start         (start),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .byte_position (byte_position),
    .last_byte     (last_byte)
  );

endmodule
